// ===== hw/rtl/bsed_pkg.sv =====
// ----------------------------------------------------------------------------
// Beacon SSID extract/dedup package
// Shared constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package bsed_pkg;

    localparam int TABLE_ENTRIES  = 128;
    localparam int SSID_MAX_BYTES = 32;
    localparam int ENT_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W   = ENT_W + 1;
    localparam int IDX_W   = $clog2(SSID_MAX_BYTES);
    localparam int LEN_W   = IDX_W + 1;
    localparam int BADDR_W = ENT_W + IDX_W;
    localparam int SSID_START_POS = 38;

    localparam logic [7:0]       BEACON_FC     = 8'h80;
    localparam logic [7:0]       TAG_NUM_POS   = 8'd36;
    localparam logic [IDX_W-1:0] SSID_START_LO = IDX_W'(SSID_START_POS % SSID_MAX_BYTES);
    localparam logic [6:0]       OFFSET_RESET  = 7'd26;
    localparam logic [7:0]       POS_MAX       = 8'd255;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;      // input byte taken: advance position
        logic set_len;     // latch tag length, clear trimmed length
        logic collect;     // store SSID byte, grow trimmed length
        logic search_init; // entry and byte index to zero
        logic next_ent;    // advance to the next table entry
        logic next_k;      // advance to the next byte of an entry
        logic miss;        // SSID is new: latch full flag, clear byte index
        logic store_wr;    // write one SSID byte into the table
        logic store_len;   // write length, bump entry count
        logic emit;        // load one result into the output register
    } ctl_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic pos_at_fc;
        logic pos_at_tag;
        logic byte_fc;
        logic byte_zero;
        logic len_ok;
        logic ssid_last;
        logic ent_done;
        logic len_match;
        logic byte_match;
        logic k_done;
        logic full;
        logic out_free;
        logic emit_last;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bsed_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bsed_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bsed_ctrl.sv =====
// ----------------------------------------------------------------------------
// Beacon SSID controller
// Frame parse phases, table search, table update and report sequencing.
// ----------------------------------------------------------------------------
`default_nettype none

module bsed_ctrl
    import bsed_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    input  wire logic     frame_end,
    output logic          in_ready,
    input  wire dp_stat_t stat,
    output ctl_cmd_t      cmd
);

    typedef enum logic [3:0] {
        P_WAIT_FC,
        P_FIXED,
        P_LEN,
        P_COLLECT,
        P_AFTER_ZERO,
        P_DONE,
        S_ISSUE,
        S_CHK,
        S_STORE,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   ret_wait_reg, ret_wait_next;  // frame ended with the last SSID byte
    logic   parsing;
    logic   accept;

    assign parsing = (state_reg == P_WAIT_FC) || (state_reg == P_FIXED) ||
                     (state_reg == P_LEN) || (state_reg == P_COLLECT) ||
                     (state_reg == P_AFTER_ZERO) || (state_reg == P_DONE);
    assign in_ready = parsing;
    assign accept   = in_valid && parsing;

    always_comb
    begin
        state_next    = state_reg;
        ret_wait_next = ret_wait_reg;
        cmd           = '0;
        cmd.accept    = accept;
        case (state_reg)
            P_WAIT_FC:
            begin
                if (accept && stat.pos_at_fc)
                begin
                    state_next = stat.byte_fc ? P_FIXED : P_DONE;
                end
            end
            P_FIXED:
            begin
                if (accept && stat.pos_at_tag)
                begin
                    state_next = stat.byte_zero ? P_LEN : P_DONE;
                end
            end
            P_LEN:
            begin
                if (accept)
                begin
                    cmd.set_len = stat.len_ok;
                    state_next  = stat.len_ok ? P_COLLECT : P_DONE;
                end
            end
            P_COLLECT, P_AFTER_ZERO:
            begin
                if (accept)
                begin
                    if (state_reg == P_COLLECT)
                    begin
                        if (stat.byte_zero)
                        begin
                            state_next = P_AFTER_ZERO;
                        end
                        else
                        begin
                            cmd.collect = 1'b1;
                        end
                    end
                    if (stat.ssid_last)
                    begin
                        cmd.search_init = 1'b1;
                        ret_wait_next   = frame_end;
                        state_next      = S_ISSUE;
                    end
                end
            end
            P_DONE:
            begin
            end
            S_ISSUE:
            begin
                if (stat.ent_done)
                begin
                    cmd.miss   = 1'b1;
                    state_next = stat.full ? S_EMIT : S_STORE;
                end
                else
                begin
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                state_next = S_ISSUE;
                if (!stat.len_match)
                begin
                    cmd.next_ent = 1'b1;
                end
                else if (stat.k_done)
                begin
                    // duplicate: drop the report
                    state_next = ret_wait_reg ? P_WAIT_FC : P_DONE;
                end
                else if (!stat.byte_match)
                begin
                    cmd.next_ent = 1'b1;
                end
                else
                begin
                    cmd.next_k = 1'b1;
                end
            end
            S_STORE:
            begin
                if (stat.k_done)
                begin
                    cmd.store_len = 1'b1;
                    state_next    = S_EMIT;
                end
                else
                begin
                    cmd.store_wr = 1'b1;
                end
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (stat.emit_last)
                    begin
                        state_next = ret_wait_reg ? P_WAIT_FC : P_DONE;
                    end
                end
            end
            default:
            begin
                state_next = P_WAIT_FC;
            end
        endcase
        // frame end restarts parsing, but not while a report is pending
        if (accept && frame_end && (state_next != S_ISSUE))
        begin
            state_next = P_WAIT_FC;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= P_WAIT_FC;
            ret_wait_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            ret_wait_reg <= ret_wait_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bsed_dpath.sv =====
// ----------------------------------------------------------------------------
// Beacon SSID datapath
// Position counter, SSID buffer, seen-SSID table and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bsed_dpath
    import bsed_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_wr,
    input  wire logic [6:0] cfg_offset,
    input  wire logic [7:0] frame_byte,
    input  wire logic       frame_end,
    input  wire ctl_cmd_t   cmd,
    output dp_stat_t        stat,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      ssid_byte,
    output logic [5:0]      ssid_length,
    output logic            not_stored,
    output logic            last_byte
);

    logic [6:0]       offset_reg;
    logic [7:0]       pos_reg;
    logic [LEN_W-1:0] tag_len_reg;
    logic [LEN_W-1:0] trim_reg;
    logic [7:0]       buf_reg [SSID_MAX_BYTES];
    logic [CNT_W-1:0] ent_reg;
    logic [LEN_W-1:0] k_reg;
    logic [CNT_W-1:0] count_reg;
    logic             full_reg;
    logic             out_valid_reg;
    logic [7:0]       out_byte_reg;
    logic [5:0]       out_len_reg;
    logic             out_full_reg;
    logic             out_last_reg;

    logic [IDX_W-1:0] idx;
    logic [7:0]       bytes_q;
    logic [LEN_W-1:0] len_q;
    logic [7:0]       buf_k;
    logic [LEN_W-1:0] k_inc;

    assign idx   = pos_reg[IDX_W-1:0] - offset_reg[IDX_W-1:0] - SSID_START_LO;
    assign buf_k = buf_reg[k_reg[IDX_W-1:0]];
    assign k_inc = k_reg + LEN_W'(1);

    bsed_ram #(.WIDTH(8), .DEPTH(TABLE_ENTRIES * SSID_MAX_BYTES)) u_bytes (
        .clk     (clk),
        .wr_en   (cmd.store_wr),
        .wr_addr ({count_reg[ENT_W-1:0], k_reg[IDX_W-1:0]}),
        .wr_data (buf_k),
        .rd_addr ({ent_reg[ENT_W-1:0], k_reg[IDX_W-1:0]}),
        .rd_data (bytes_q)
    );

    bsed_ram #(.WIDTH(LEN_W), .DEPTH(TABLE_ENTRIES)) u_lens (
        .clk     (clk),
        .wr_en   (cmd.store_len),
        .wr_addr (count_reg[ENT_W-1:0]),
        .wr_data (trim_reg),
        .rd_addr (ent_reg[ENT_W-1:0]),
        .rd_data (len_q)
    );

    always_comb
    begin
        stat            = '0;
        stat.pos_at_fc  = (pos_reg == {1'b0, offset_reg});
        stat.pos_at_tag = (pos_reg == ({1'b0, offset_reg} + TAG_NUM_POS));
        stat.byte_fc    = (frame_byte == BEACON_FC);
        stat.byte_zero  = (frame_byte == 8'd0);
        stat.len_ok     = (frame_byte != 8'd0) && (frame_byte <= 8'(SSID_MAX_BYTES));
        stat.ssid_last  = (({1'b0, idx} + LEN_W'(1)) >= tag_len_reg);
        stat.ent_done   = (ent_reg >= count_reg);
        stat.len_match  = (len_q == trim_reg);
        stat.byte_match = (bytes_q == buf_k);
        stat.k_done     = (k_reg >= trim_reg);
        stat.full       = (count_reg >= CNT_W'(TABLE_ENTRIES));
        stat.out_free   = !out_valid_reg || out_ready;
        stat.emit_last  = (k_inc >= trim_reg);
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg    <= OFFSET_RESET;
            pos_reg       <= '0;
            tag_len_reg   <= '0;
            trim_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                offset_reg <= cfg_offset;
            end
            if (cmd.accept)
            begin
                if (frame_end)
                begin
                    pos_reg <= '0;
                end
                else if (pos_reg != POS_MAX)
                begin
                    pos_reg <= pos_reg + 8'd1;
                end
            end
            if (cmd.set_len)
            begin
                tag_len_reg <= frame_byte[LEN_W-1:0];
                trim_reg    <= '0;
            end
            if (cmd.collect)
            begin
                trim_reg <= {1'b0, idx} + LEN_W'(1);
            end
            if (cmd.store_len)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload and search indexes
    always_ff @(posedge clk)
    begin
        if (cmd.collect)
        begin
            buf_reg[idx] <= frame_byte;
        end
        if (cmd.search_init || cmd.next_ent)
        begin
            ent_reg <= cmd.search_init ? '0 : ent_reg + CNT_W'(1);
        end
        if (cmd.search_init || cmd.next_ent || cmd.miss || cmd.store_len)
        begin
            k_reg <= '0;
        end
        else if (cmd.next_k || cmd.store_wr || cmd.emit)
        begin
            k_reg <= k_inc;
        end
        if (cmd.miss)
        begin
            full_reg <= stat.full;
        end
        if (cmd.emit)
        begin
            out_byte_reg <= (trim_reg == '0) ? 8'd0 : buf_k;
            out_len_reg  <= trim_reg;
            out_full_reg <= full_reg;
            out_last_reg <= stat.emit_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign ssid_byte   = out_byte_reg;
    assign ssid_length = out_len_reg;
    assign not_stored  = out_full_reg;
    assign last_byte   = out_last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_ENTRIES))
        else $error("entry count beyond table size");
    a_trim_bound: assert property (@(posedge clk) disable iff (!rst_n)
        trim_reg <= tag_len_reg)
        else $error("trimmed length exceeds tag length");
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_len_reg == 6'd0) |-> out_last_reg)
        else $error("empty SSID report must be a single last item");
    a_no_store_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store_len |-> !stat.full)
        else $error("store into a full table");

endmodule

`default_nettype wire

// ===== hw/rtl/beacon_ssid_extract_dedup_unit.sv =====
// ----------------------------------------------------------------------------
// Beacon SSID extract and dedup unit
// Finds the SSID tag in captured beacon frames and reports new SSIDs once.
// ----------------------------------------------------------------------------
// Usage:
//   Frame bytes arrive on the in_* channel, one transfer per byte, with
//   frame_end on the final byte. The header_offset port (cfg_valid/ready)
//   sets the radiotap header length; write it only while the unit is idle.
//   Each newly seen SSID comes out on the out_* channel as one transfer per
//   SSID byte (one transfer for an empty SSID), last_byte on the final one.
// Timing:
//   Frame bytes are taken one per cycle while parsing. On the byte that completes
//   an SSID the input stalls while the table is searched: each entry probe reads
//   its stored length, then compares matching bytes one at a time through the
//   single read port of the seen-SSID memory. A new SSID is then recorded byte
//   by byte, then its length, and each report item waits for a free output register.
// Reset:
//   Clears parse state and the entry count; header_offset returns to 26.
//   Table memory is not cleared: only entries below the count are read.
// Backpressure:
//   A stalled receiver holds the report in the output register; the input
//   stays closed until the report has fully drained into that register.
// ----------------------------------------------------------------------------
`default_nettype none

module beacon_ssid_extract_dedup_unit
    import bsed_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    // configuration
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [6:0] header_offset,
    // frame bytes
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] frame_byte,
    input  wire logic       frame_end,
    // SSID reports
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      ssid_byte,
    output logic [5:0]      ssid_length,
    output logic            not_stored,
    output logic            last_byte
);

    ctl_cmd_t cmd;
    dp_stat_t stat;

    // register always writable
    assign cfg_ready = 1'b1;

    bsed_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .frame_end (frame_end),
        .in_ready  (in_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    bsed_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr      (cfg_valid),
        .cfg_offset  (header_offset),
        .frame_byte  (frame_byte),
        .frame_end   (frame_end),
        .cmd         (cmd),
        .stat        (stat),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .ssid_byte   (ssid_byte),
        .ssid_length (ssid_length),
        .not_stored  (not_stored),
        .last_byte   (last_byte)
    );

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// Beacon SSID extract/dedup testbench
// Streams beacon-like frames into the unit, predicts the SSID reports with
// an in-bench parser and seen-SSID table, and checks every output transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    import bsed_pkg::*;

    typedef enum logic [2:0] {
        PH_WAIT_FC, PH_FIXED, PH_LEN, PH_COLLECT, PH_AFTER_ZERO, PH_DONE
    } parse_ph_t;

    typedef enum int {
        FK_GOOD, FK_BAD_FC, FK_BAD_TAG, FK_BAD_LEN, FK_SHORT, FK_NOISE
    } frame_kind_t;

    typedef struct packed {
        logic [7:0] fbyte;
        logic       fend;
    } frame_item_t;

    typedef struct packed {
        logic [7:0] sbyte;
        logic [5:0] slen;
        logic       nstored;
        logic       last;
    } ssid_item_t;

    localparam int ITEM_TARGET = 470;
    localparam int CYCLE_LIMIT = 200000;

    logic       clk;
    logic       rst_n;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [6:0] header_offset;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] frame_byte;
    logic       frame_end;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] ssid_byte;
    logic [5:0] ssid_length;
    logic       not_stored;
    logic       last_byte;

    beacon_ssid_extract_dedup_unit uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .header_offset(header_offset),
        .in_valid(in_valid), .in_ready(in_ready),
        .frame_byte(frame_byte), .frame_end(frame_end),
        .out_valid(out_valid), .out_ready(out_ready),
        .ssid_byte(ssid_byte), .ssid_length(ssid_length),
        .not_stored(not_stored), .last_byte(last_byte)
    );

    always
    begin
        clk = 1'b1; #1;
        clk = 1'b0; #1;
    end

    // Predictor state: parser plus the seen-SSID table
    logic [6:0]  p_offset;
    logic [7:0]  p_pos;
    parse_ph_t   p_phase;
    logic [5:0]  p_taglen;
    logic [5:0]  p_trim;
    logic [7:0]  p_buf [SSID_MAX_BYTES];
    logic [7:0]  p_tbl [TABLE_ENTRIES][SSID_MAX_BYTES];
    logic [5:0]  p_tlen [TABLE_ENTRIES];
    int          p_count;

    frame_item_t frame_q [$];
    ssid_item_t  ssid_expect_q [$];

    int  send_idle_pct;
    int  recv_idle_pct;
    int  mismatches;
    int  cycles;
    int  n_sent;
    logic in_taken;
    logic [7:0] seed_ssids [2][SSID_MAX_BYTES];
    int  seed_lens [2];

    // Compare the trimmed SSID with the table; on a miss queue the report
    // and record it while there is room.
    task automatic report_if_new();
        bit hit;
        bit same;
        bit full;
        int n;
        ssid_item_t it;
        hit = 0;
        for (int e = 0; e < p_count && !hit; e++)
        begin
            if (p_tlen[e] == p_trim)
            begin
                same = 1;
                for (int k = 0; k < p_trim; k++)
                    if (p_tbl[e][k] != p_buf[k]) same = 0;
                if (same) hit = 1;
            end
        end
        if (hit) return;
        full = (p_count >= TABLE_ENTRIES);
        if (!full)
        begin
            for (int k = 0; k < p_trim; k++) p_tbl[p_count][k] = p_buf[k];
            p_tlen[p_count] = p_trim;
            p_count++;
        end
        n = (p_trim == 0) ? 1 : p_trim;
        for (int k = 0; k < n; k++)
        begin
            it.sbyte   = (p_trim == 0) ? 8'd0 : p_buf[k];
            it.slen    = p_trim;
            it.nstored = full;
            it.last    = (k + 1 == n);
            ssid_expect_q.push_back(it);
        end
    endtask

    task automatic parse_byte(input frame_item_t fi);
        logic [IDX_W-1:0] idx;
        case (p_phase)
            PH_WAIT_FC:
                if (p_pos == p_offset)
                    p_phase = (fi.fbyte == BEACON_FC) ? PH_FIXED : PH_DONE;
            PH_FIXED:
                if (int'(p_pos) == int'(p_offset) + 36)
                    p_phase = (fi.fbyte == 0) ? PH_LEN : PH_DONE;
            PH_LEN:
                if (fi.fbyte >= 1 && fi.fbyte <= SSID_MAX_BYTES)
                begin
                    p_taglen = fi.fbyte[5:0];
                    p_trim   = '0;
                    p_phase  = PH_COLLECT;
                end
                else
                    p_phase = PH_DONE;
            PH_COLLECT, PH_AFTER_ZERO:
            begin
                idx = IDX_W'(int'(p_pos) - int'(p_offset) - SSID_START_POS);
                if (p_phase == PH_COLLECT)
                begin
                    if (fi.fbyte == 0)
                        p_phase = PH_AFTER_ZERO;
                    else
                    begin
                        p_buf[idx] = fi.fbyte;
                        p_trim     = 6'(idx) + 6'd1;
                    end
                end
                if (int'(idx) + 1 >= int'(p_taglen))
                begin
                    report_if_new();
                    p_phase = PH_DONE;
                end
            end
            default: ;
        endcase
        if (fi.fend)
        begin
            p_pos   = '0;
            p_phase = PH_WAIT_FC;
        end
        else if (p_pos != POS_MAX)
            p_pos++;
    endtask

    // Build one frame: a good beacon, a wrong frame-control byte, a wrong
    // tag number, a bad tag length, a frame cut before its SSID ends, or
    // plain noise.
    task automatic queue_frame(input frame_kind_t kind, input int tlen,
                               input logic [7:0] ssid [SSID_MAX_BYTES], input int trail);
        int total;
        int cut;
        logic [7:0] b;
        frame_item_t fi;
        total = p_offset + SSID_START_POS + tlen + trail;
        cut = total;
        if (kind == FK_SHORT) cut = $urandom_range(1, p_offset + SSID_START_POS + tlen - 1);
        if (kind == FK_NOISE) cut = $urandom_range(1, 60);
        for (int i = 0; i < cut; i++)
        begin
            b = 8'($urandom);
            if (kind != FK_NOISE)
            begin
                if (i == p_offset) b = (kind == FK_BAD_FC) ? 8'(b | 8'h01) : BEACON_FC;
                else if (i == p_offset + 36)
                    b = (kind == FK_BAD_TAG) ? 8'(b | 8'h01) : 8'd0;
                else if (i == p_offset + 37)
                    b = (kind == FK_BAD_LEN) ? (($urandom_range(0, 1) == 1) ? 8'd0
                                       : 8'($urandom_range(33, 255))) : 8'(tlen);
                else if (i >= p_offset + SSID_START_POS
                         && i < p_offset + SSID_START_POS + tlen)
                    b = ssid[i - p_offset - SSID_START_POS];
            end
            fi.fbyte = b;
            fi.fend  = (i == cut - 1);
            frame_q.push_back(fi);
        end
        n_sent += cut;
    endtask

    // Random SSID content: mostly printable, sometimes a zero inside
    task automatic make_ssid(output logic [7:0] s [SSID_MAX_BYTES], input int tlen);
        for (int k = 0; k < SSID_MAX_BYTES; k++)
            s[k] = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(33, 126));
        if ($urandom_range(0, 7) == 0) s[$urandom_range(0, tlen - 1)] = 8'd0;
    endtask

    // Wait until every byte is taken, the search is over and the last
    // report has left the output register.
    task automatic wait_drain();
        while (frame_q.size() != 0) @(negedge clk);
        @(negedge clk);
        while (!in_ready || out_valid || ssid_expect_q.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_offset(input logic [6:0] v);
        @(negedge clk);
        cfg_valid     <= 1'b1;
        header_offset <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        p_offset = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Driver: hold valid until the transfer, advance on accept
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_taken)
        begin
            if (frame_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                in_valid   <= 1'b1;
                frame_byte <= frame_q[0].fbyte;
                frame_end  <= frame_q[0].fend;
            end
            else
                in_valid <= 1'b0;
        end
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Take each accepted byte off the queue and run it through the predictor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_taken <= 1'b0;
        else
        begin
            in_taken <= in_valid && in_ready;
            if (in_valid && in_ready)
                parse_byte(frame_q.pop_front());
        end
    end

    // Monitor: compare each report transfer with the oldest expectation
    always @(posedge clk)
    begin
        ssid_item_t got;
        ssid_item_t exp_it;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{ssid_byte, ssid_length, not_stored, last_byte};
            if (ssid_expect_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected report transfer: byte %h len %0d ns %b last %b",
                             ssid_byte, ssid_length, not_stored, last_byte);
            end
            else
            begin
                exp_it = ssid_expect_q.pop_front();
                if (got != exp_it)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"report mismatch: exp byte %h len %0d ns %b last %b,",
                                  " got byte %h len %0d ns %b last %b"},
                                 exp_it.sbyte, exp_it.slen, exp_it.nstored, exp_it.last,
                                 got.sbyte, got.slen, got.nstored, got.last);
                end
            end
        end
    end

    // Watchdog: far above a run where every report stalls on the receiver
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        logic [7:0] s [SSID_MAX_BYTES];
        int tlen;
        frame_kind_t kind;
        int pick;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        header_offset = OFFSET_RESET;
        send_idle_pct = 22;
        recv_idle_pct = 59;
        n_sent = 0;
        p_offset = OFFSET_RESET;
        p_pos = '0;
        p_phase = PH_WAIT_FC;
        p_taglen = '0;
        p_trim = '0;
        p_count = 0;
        for (int k = 0; k < SSID_MAX_BYTES; k++) p_buf[k] = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Receiver idles more: longest SSID at the reset offset, ending on
        // frame_end, then its duplicate and an empty SSID at offset zero
        for (int k = 0; k < SSID_MAX_BYTES; k++) s[k] = 8'hFF - 8'(k);
        queue_frame(FK_GOOD, 32, s, 0);
        wait_drain();
        write_offset(7'd0);
        queue_frame(FK_GOOD, 32, s, 1);
        s[0] = 8'h00;
        queue_frame(FK_GOOD, 3, s, 0);
        wait_drain();

        // Sender idles more: repeated empty SSID, rejects, short frame
        send_idle_pct = 59;
        recv_idle_pct = 22;
        queue_frame(FK_GOOD, 3, s, 1);
        queue_frame(FK_BAD_FC, 1, s, 0);
        queue_frame(FK_BAD_TAG, 1, s, 0);
        queue_frame(FK_BAD_LEN, 1, s, 0);
        queue_frame(FK_SHORT, 4, s, 0);
        wait_drain();

        // No idling: random frames at a small random offset, with repeats
        // drawn from a small pool
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 2; i++)
        begin
            seed_lens[i] = $urandom_range(1, 6);
            for (int k = 0; k < SSID_MAX_BYTES; k++)
                seed_ssids[i][k] = 8'($urandom_range(65, 90));
        end
        write_offset(7'($urandom_range(0, 8)));
        while (n_sent < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 99);
            kind = (pick < 80) ? FK_GOOD : frame_kind_t'(1 + (pick % 5));
            tlen = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 32) : $urandom_range(1, 4);
            make_ssid(s, tlen);
            if ($urandom_range(0, 1) == 0)
            begin
                pick = $urandom_range(0, 1);
                tlen = seed_lens[pick];
                s = seed_ssids[pick];
            end
            queue_frame(kind, tlen, s, $urandom_range(0, 3));
        end
        wait_drain();

        if (mismatches == 0 && ssid_expect_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
